// ===== src/fragment_send_ack_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// Fragment send/ack tracker assertion macros
// Shared concurrent assertion forms; NO_ASSERTIONS compiles them out.
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_SEND_ACK_TRACKER_DEFINES_SVH
`define FRAGMENT_SEND_ACK_TRACKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Expression holds on every clock edge out of reset.
`define FST_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define FST_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define FST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FST_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define FST_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define FST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/fst_pkg.sv =====
// ----------------------------------------------------------------------------
// Fragment send/ack tracker package
// Field widths, operation and register codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package fst_pkg;

    localparam int TOTAL_W    = 24;
    localparam int MTU_W      = 16;
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 8;
    localparam int LEN_W      = 17;
    localparam int MODE_W     = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_CNT_W  = $clog2(TOTAL_W + 1);

    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FETCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ACK   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] CFG_MTU      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTERVAL = 2'd1;

    localparam logic [MTU_W-1:0]  MTU_RESET      = 16'd500;
    localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd10;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic div_go;
        logic scan_init;
        logic scan_step;
        logic mul_go;
        logic commit;
    } fst_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              div_done;
        logic              scan_hit;
        logic              scan_end;
        logic              out_free;
    } fst_stat_t;

endpackage

// ===== src/fst_div.sv =====
// ----------------------------------------------------------------------------
// Fragment count divider
// Restoring divider, one quotient bit per cycle; reports quotient and
// whether the remainder is nonzero.
// ----------------------------------------------------------------------------
module fst_div
    import fst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [TOTAL_W-1:0] dividend,
    input  logic [MTU_W-1:0]   divisor,
    output logic [TOTAL_W-1:0] quotient,
    output logic               rem_nz,
    output logic               done
);

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(TOTAL_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [TOTAL_W-1:0]   quot_reg;
    logic [MTU_W-1:0]     rem_reg;
    logic [MTU_W-1:0]     dvs_reg;

    logic [MTU_W:0]       shifted;
    logic [MTU_W:0]       diff;
    logic                 fits;
    logic [MTU_W-1:0]     rem_next;
    logic [TOTAL_W-1:0]   quot_next;

    always_comb
    begin
        shifted   = {rem_reg, quot_reg[TOTAL_W-1]};
        fits      = shifted >= {1'b0, dvs_reg};
        diff      = shifted - {1'b0, dvs_reg};
        rem_next  = fits ? diff[MTU_W-1:0] : shifted[MTU_W-1:0];
        quot_next = {quot_reg[TOTAL_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign quotient = quot_reg;
    assign rem_nz   = |rem_reg;
    assign done     = done_reg;

endmodule

// ===== src/fst_datapath.sv =====
// ----------------------------------------------------------------------------
// Fragment send/ack tracker datapath
// Config registers, per-fragment timestamp memory and flags, table scan
// pipeline, offset/length arithmetic and the output word register.
// ----------------------------------------------------------------------------
`include "fragment_send_ack_tracker_defines.svh"

module fst_datapath
    import fst_pkg::*;
#(
    parameter int MAX_FRAGMENTS = 64,
    parameter int HEADER_BYTES  = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [MODE_W-1:0]     mode,
    input  logic [TOTAL_W-1:0]    total_bytes,
    input  logic [TIME_W-1:0]     now_time,
    input  logic                  resend,
    input  logic [CNT_W-1:0]      ack_part,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  found,
    output logic [CNT_W-1:0]      fragment_index,
    output logic [TOTAL_W-1:0]    fragment_offset,
    output logic [LEN_W-1:0]      fragment_length,
    output logic [CNT_W-1:0]      fragment_count,
    output logic                  all_acked,
    output logic                  too_many,
    input  fst_cmd_t              cmd,
    output fst_stat_t             stat
);

    localparam int IDX_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
    localparam logic [CNT_W-1:0]   MAX_CNT  = CNT_W'(MAX_FRAGMENTS);
    localparam logic [TOTAL_W:0]   MAX_WIDE = (TOTAL_W + 1)'(MAX_FRAGMENTS);
    localparam logic [LEN_W-1:0]   HDR_LEN  = LEN_W'(HEADER_BYTES);

    // Configuration
    logic [MTU_W-1:0]  mtu_reg;
    logic [TIME_W-1:0] interval_reg;
    logic [MTU_W-1:0]  mtu_eff;

    // Latched input word
    logic [MODE_W-1:0]  mode_in_reg;
    logic [TOTAL_W-1:0] total_in_reg;
    logic [TIME_W-1:0]  now_in_reg;
    logic               resend_in_reg;
    logic [CNT_W-1:0]   part_in_reg;

    // Datagram state
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         unacked_left_reg;
    logic [TOTAL_W-1:0]       buffer_total_reg;
    logic [MTU_W-1:0]         frag_size_reg;
    logic [MAX_FRAGMENTS-1:0] done_bits_reg;
    logic [MAX_FRAGMENTS-1:0] sent_bits_reg;
    logic [TIME_W-1:0]        sent_mem [MAX_FRAGMENTS];

    // Scan pipeline
    logic [CNT_W-1:0]  scan_addr_reg;
    logic              pipe_valid_reg;
    logic [CNT_W-1:0]  pipe_idx_reg;
    logic [TIME_W-1:0] mem_rd_reg;
    logic              hit_reg;
    logic [CNT_W-1:0]  hit_idx_reg;

    // Fetch arithmetic
    logic [TOTAL_W-1:0] start_reg;
    logic [TOTAL_W-1:0] off_reg;

    // Output word
    logic               out_valid_reg;
    logic               found_reg;
    logic [CNT_W-1:0]   index_reg;
    logic [TOTAL_W-1:0] offset_reg;
    logic [LEN_W-1:0]   length_reg;
    logic [CNT_W-1:0]   count_out_reg;
    logic               all_acked_reg;
    logic               too_many_reg;

    // Divider
    logic [TOTAL_W-1:0] div_quot;
    logic               div_rem_nz;
    logic               div_done;

    logic               ent_done;
    logic               ent_sent;
    logic [TIME_W-1:0]  ent_time;
    logic [TIME_W-1:0]  ent_age;
    logic               ent_match;

    logic [TOTAL_W:0]   cnt_full;
    logic               start_too;
    logic [CNT_W-1:0]   cnt_sat;
    logic [CNT_W-1:0]   part_m1;
    logic               ack_ok;
    logic [TOTAL_W-1:0] rem_bytes;
    logic [MTU_W-1:0]   pay_bytes;
    logic [TOTAL_W:0]   off_prod;

    logic               res_found;
    logic [CNT_W-1:0]   res_index;
    logic [TOTAL_W-1:0] res_offset;
    logic [LEN_W-1:0]   res_length;
    logic [CNT_W-1:0]   res_count;
    logic               res_all_acked;
    logic               res_too_many;

    assign mtu_eff = (mtu_reg == '0) ? MTU_W'(1) : mtu_reg;

    fst_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .dividend (total_in_reg),
        .divisor  (mtu_eff),
        .quotient (div_quot),
        .rem_nz   (div_rem_nz),
        .done     (div_done)
    );

    // Entry under evaluation; a fragment never resent counts as sent at time zero
    always_comb
    begin
        ent_done  = done_bits_reg[pipe_idx_reg[IDX_W-1:0]];
        ent_sent  = sent_bits_reg[pipe_idx_reg[IDX_W-1:0]];
        ent_time  = ent_sent ? mem_rd_reg : '0;
        ent_age   = now_in_reg - ent_time;
        ent_match = !ent_done && (resend_in_reg ? (ent_age >= interval_reg) : !ent_sent);
    end

    // Start: ceiling of the quotient, range check, saturated report
    always_comb
    begin
        cnt_full  = {1'b0, div_quot} + (TOTAL_W + 1)'(div_rem_nz);
        start_too = cnt_full > MAX_WIDE;
        cnt_sat   = (|cnt_full[TOTAL_W:CNT_W]) ? '1 : cnt_full[CNT_W-1:0];
    end

    // Acknowledge check
    always_comb
    begin
        part_m1 = part_in_reg - 1'b1;
        ack_ok  = (part_in_reg != '0) && (part_in_reg <= count_reg) &&
                  (unacked_left_reg != '0) && !done_bits_reg[part_m1[IDX_W-1:0]];
    end

    // Fetch length: header plus the payload left in this fragment
    always_comb
    begin
        rem_bytes = buffer_total_reg - start_reg;
        pay_bytes = (rem_bytes < {{(TOTAL_W - MTU_W){1'b0}}, frag_size_reg}) ?
                    rem_bytes[MTU_W-1:0] : frag_size_reg;
        off_prod  = (TOTAL_W + 1)'(hit_idx_reg) *
                    (TOTAL_W + 1)'({1'b0, frag_size_reg} + HDR_LEN);
    end

    always_comb
    begin
        res_found     = 1'b0;
        res_index     = '0;
        res_offset    = '0;
        res_length    = '0;
        res_count     = count_reg;
        res_all_acked = 1'b0;
        res_too_many  = 1'b0;
        case (mode_in_reg)
            MODE_START:
            begin
                res_found    = !start_too;
                res_count    = cnt_sat;
                res_too_many = start_too;
            end
            MODE_FETCH:
            begin
                if (hit_reg)
                begin
                    res_found  = 1'b1;
                    res_index  = hit_idx_reg;
                    res_offset = off_reg;
                    res_length = HDR_LEN + {1'b0, pay_bytes};
                end
            end
            MODE_ACK:
            begin
                res_found     = ack_ok;
                res_all_acked = ack_ok && (unacked_left_reg == CNT_W'(1));
            end
            default:
            begin
                res_found = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtu_reg          <= MTU_RESET;
            interval_reg     <= INTERVAL_RESET;
            count_reg        <= '0;
            unacked_left_reg <= '0;
            buffer_total_reg <= '0;
            frag_size_reg    <= MTU_W'(1);
            done_bits_reg    <= '0;
            sent_bits_reg    <= '0;
            scan_addr_reg    <= '0;
            pipe_valid_reg   <= 1'b0;
            hit_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    CFG_MTU:      mtu_reg      <= cfg_wdata[MTU_W-1:0];
                    CFG_INTERVAL: interval_reg <= cfg_wdata[TIME_W-1:0];
                    default:      ;
                endcase
            end

            if (cmd.scan_init)
            begin
                scan_addr_reg  <= '0;
                pipe_valid_reg <= 1'b0;
                hit_reg        <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (stat.scan_hit)
                begin
                    hit_reg        <= 1'b1;
                    pipe_valid_reg <= 1'b0;
                end
                else if (scan_addr_reg < count_reg)
                begin
                    pipe_valid_reg <= 1'b1;
                    scan_addr_reg  <= scan_addr_reg + 1'b1;
                end
                else
                begin
                    pipe_valid_reg <= 1'b0;
                end
            end

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                hit_reg       <= 1'b0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.commit)
            begin
                case (mode_in_reg)
                    MODE_START:
                    begin
                        done_bits_reg <= '0;
                        sent_bits_reg <= '0;
                        frag_size_reg <= mtu_eff;
                        if (start_too)
                        begin
                            count_reg        <= '0;
                            unacked_left_reg <= '0;
                            buffer_total_reg <= '0;
                        end
                        else
                        begin
                            count_reg        <= cnt_full[CNT_W-1:0];
                            unacked_left_reg <= cnt_full[CNT_W-1:0];
                            buffer_total_reg <= total_in_reg;
                        end
                    end
                    MODE_FETCH:
                    begin
                        if (hit_reg)
                        begin
                            if (resend_in_reg)
                                sent_bits_reg[hit_idx_reg[IDX_W-1:0]] <= 1'b1;
                            else
                                done_bits_reg[hit_idx_reg[IDX_W-1:0]] <= 1'b1;
                        end
                    end
                    MODE_ACK:
                    begin
                        if (ack_ok)
                        begin
                            done_bits_reg[part_m1[IDX_W-1:0]] <= 1'b1;
                            unacked_left_reg <= unacked_left_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                        count_reg <= count_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_in_reg   <= mode;
            total_in_reg  <= total_bytes;
            now_in_reg    <= now_time;
            resend_in_reg <= resend;
            part_in_reg   <= ack_part;
        end
        if (cmd.scan_step)
        begin
            pipe_idx_reg <= scan_addr_reg;
            if (stat.scan_hit)
                hit_idx_reg <= pipe_idx_reg;
        end
        if (cmd.mul_go)
        begin
            start_reg <= TOTAL_W'(hit_idx_reg) * TOTAL_W'(frag_size_reg);
            off_reg   <= off_prod[TOTAL_W-1:0];
        end
        if (cmd.commit)
        begin
            found_reg     <= res_found;
            index_reg     <= res_index;
            offset_reg    <= res_offset;
            length_reg    <= res_length;
            count_out_reg <= res_count;
            all_acked_reg <= res_all_acked;
            too_many_reg  <= res_too_many;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && (mode_in_reg == MODE_FETCH) && hit_reg && resend_in_reg)
            sent_mem[hit_idx_reg[IDX_W-1:0]] <= now_in_reg;
        mem_rd_reg <= sent_mem[scan_addr_reg[IDX_W-1:0]];
    end

    assign stat.mode     = mode_in_reg;
    assign stat.div_done = div_done;
    assign stat.scan_hit = pipe_valid_reg && ent_match;
    assign stat.scan_end = !pipe_valid_reg && (scan_addr_reg >= count_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign found           = found_reg;
    assign fragment_index  = index_reg;
    assign fragment_offset = offset_reg;
    assign fragment_length = length_reg;
    assign fragment_count  = count_out_reg;
    assign all_acked       = all_acked_reg;
    assign too_many        = too_many_reg;

    `FST_ASSERT_ALWAYS(a_unacked_le_count, clk, rst_n, unacked_left_reg <= count_reg, "unacked count exceeds fragment count")
    `FST_ASSERT_ALWAYS(a_count_fits_table, clk, rst_n, count_reg <= MAX_CNT, "fragment count exceeds table size")
    `FST_ASSERT_IMPLY(a_hit_in_range, clk, rst_n, hit_reg, hit_idx_reg < count_reg, "scan hit beyond fragment count")

endmodule

// ===== src/fst_ctrl.sv =====
// ----------------------------------------------------------------------------
// Fragment send/ack tracker controller
// Sequences decode, divide, table scan, arithmetic and result commit.
// ----------------------------------------------------------------------------
`include "fragment_send_ack_tracker_defines.svh"

module fst_ctrl
    import fst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  fst_stat_t stat,
    output fst_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_SCAN,
        S_MUL,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = in_valid;
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                case (stat.mode)
                    MODE_START:
                    begin
                        cmd.div_go = 1'b1;
                        state_next = S_DIV;
                    end
                    MODE_FETCH:
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_RESULT;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_hit)
                    state_next = S_MUL;
                else if (stat.scan_end)
                    state_next = S_RESULT;
            end
            S_MUL:
            begin
                cmd.mul_go = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    `FST_ASSERT_IMPLY(a_commit_slot_free, clk, rst_n, cmd.commit, stat.out_free, "result committed over an untaken word")
    `FST_ASSERT_IMPLY(a_div_done_in_wait, clk, rst_n, stat.div_done, state_reg == S_DIV, "divider finished outside its wait state")
    `FST_ASSERT_NEXT(a_ready_after_commit, clk, rst_n, cmd.commit, in_ready, "not ready after result commit")

endmodule

// ===== src/fragment_send_ack_tracker.sv =====
// ----------------------------------------------------------------------------
// Fragment send/ack tracker
// Send-side selective-repeat bookkeeping for one fragmented datagram.
// ----------------------------------------------------------------------------
// Take one input word at a time and return exactly one result word for it.
// A start word (mode 0) divides the payload length by the fragment size
// with a restoring divider, one quotient bit per cycle. A fetch word (mode 1)
// walks the fragment table one entry per cycle through the registered read
// port of the timestamp memory, stopping at the first eligible fragment.
// Acknowledge and no-op words (modes 2 and 3) need no divide or scan. The
// result sits in an output register, so the next input word is taken while a
// result still waits for out_ready. Starting a datagram clears the per-fragment
// done and sent flags at once; a timestamp entry whose sent flag is clear
// reads as time zero, so no clearing pass over the memory is needed, after
// reset or at start.
// Write payload_per_fragment (index 0) and resend_interval (index 1) only
// while no word is in flight; other indexes are ignored.
// ----------------------------------------------------------------------------
module fragment_send_ack_tracker
    import fst_pkg::*;
#(
    parameter int MAX_FRAGMENTS = 64,
    parameter int HEADER_BYTES  = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // Input word
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MODE_W-1:0]     mode,
    input  logic [TOTAL_W-1:0]    total_bytes,
    input  logic [TIME_W-1:0]     now_time,
    input  logic                  resend,
    input  logic [CNT_W-1:0]      ack_part,

    // Result word
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  found,
    output logic [CNT_W-1:0]      fragment_index,
    output logic [TOTAL_W-1:0]    fragment_offset,
    output logic [LEN_W-1:0]      fragment_length,
    output logic [CNT_W-1:0]      fragment_count,
    output logic                  all_acked,
    output logic                  too_many
);

    fst_cmd_t  cmd;
    fst_stat_t stat;

    // Sequence each word: decode, then divide, scan (and multiply) or check, then commit
    fst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the datagram state, the table and the result register
    fst_datapath #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS),
        .HEADER_BYTES  (HEADER_BYTES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .mode            (mode),
        .total_bytes     (total_bytes),
        .now_time        (now_time),
        .resend          (resend),
        .ack_part        (ack_part),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .found           (found),
        .fragment_index  (fragment_index),
        .fragment_offset (fragment_offset),
        .fragment_length (fragment_length),
        .fragment_count  (fragment_count),
        .all_acked       (all_acked),
        .too_many        (too_many),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule
